>>> sv/scalar_kalman_filter_assert.svh
// assertion macros for the scalar kalman filter
// no dependencies; included by the modules that check their own logic
`ifndef SCALAR_KALMAN_FILTER_ASSERT_SVH
`define SCALAR_KALMAN_FILTER_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define SKF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("skf check failed");

// antecedent implies consequent in the next cycle
`define SKF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("skf check failed");

`else

`define SKF_ASSERT_NOW(label, clk, rst, ante, cons)
`define SKF_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> sv/skf_pkg.sv
// shared constants, register indexes and control store of the kalman filter
// no dependencies; imported by scalar_kalman_filter
package skf_pkg;

   localparam int FRAC_BITS_DEF    = 16;
   localparam int SAMPLE_WIDTH_DEF = 24;

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] REG_PROCESS_NOISE      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MEASUREMENT_NOISE  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_INITIAL_ESTIMATE   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_INITIAL_COVARIANCE = 2'd3;

   // datapath operations
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_WAIT  = 3'd0;
   localparam logic [OP_W-1:0] OP_ADDPP = 3'd1;
   localparam logic [OP_W-1:0] OP_SETUP = 3'd2;
   localparam logic [OP_W-1:0] OP_DIV   = 3'd3;
   localparam logic [OP_W-1:0] OP_MULX  = 3'd4;
   localparam logic [OP_W-1:0] OP_MULP  = 3'd5;
   localparam logic [OP_W-1:0] OP_WRITE = 3'd6;

   // conditions that keep the sequencer on its current step
   localparam int HOLD_W = 2;
   localparam logic [HOLD_W-1:0] HOLD_NEVER    = 2'd0;
   localparam logic [HOLD_W-1:0] HOLD_NO_ITEM  = 2'd1;
   localparam logic [HOLD_W-1:0] HOLD_DIV_BUSY = 2'd2;
   localparam logic [HOLD_W-1:0] HOLD_OUT_BUSY = 2'd3;

   // program steps
   localparam int PC_W = 3;
   localparam logic [PC_W-1:0] STEP_WAIT  = 3'd0;
   localparam logic [PC_W-1:0] STEP_ADDPP = 3'd1;
   localparam logic [PC_W-1:0] STEP_SETUP = 3'd2;
   localparam logic [PC_W-1:0] STEP_DIV   = 3'd3;
   localparam logic [PC_W-1:0] STEP_MULX  = 3'd4;
   localparam logic [PC_W-1:0] STEP_MULP  = 3'd5;
   localparam logic [PC_W-1:0] STEP_WRITE = 3'd6;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [HOLD_W-1:0] hold;
      logic [PC_W-1:0]   target;
   } ucode_type;

   // control store: one word per step, target is taken once the hold clears
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      case (pc)
         STEP_WAIT:  w = '{op: OP_WAIT,  hold: HOLD_NO_ITEM,  target: STEP_ADDPP};
         STEP_ADDPP: w = '{op: OP_ADDPP, hold: HOLD_NEVER,    target: STEP_SETUP};
         STEP_SETUP: w = '{op: OP_SETUP, hold: HOLD_NEVER,    target: STEP_DIV};
         STEP_DIV:   w = '{op: OP_DIV,   hold: HOLD_DIV_BUSY, target: STEP_MULX};
         STEP_MULX:  w = '{op: OP_MULX,  hold: HOLD_NEVER,    target: STEP_MULP};
         STEP_MULP:  w = '{op: OP_MULP,  hold: HOLD_NEVER,    target: STEP_WRITE};
         STEP_WRITE: w = '{op: OP_WRITE, hold: HOLD_OUT_BUSY, target: STEP_WAIT};
         default:    w = '{op: OP_WAIT,  hold: HOLD_NEVER,    target: STEP_WAIT};
      endcase
      return w;
   endfunction

endpackage

>>> sv/scalar_kalman_filter.sv
// one-dimensional kalman filter: microcoded sequencer over a small fixed-point datapath
// depends on skf_pkg and scalar_kalman_filter_assert.svh
//
// Each accepted item runs through a seven-step control program: accept, grow the
// covariance by q, form the denominator, a restoring divider that yields one gain bit
// per cycle, the estimate product, the covariance product and the write of the result
// register. The write step waits only while the previous result has not been taken.
// A new item is accepted while the result of the previous one still sits in the output
// register. Configuration registers may be written at any time the block is idle;
// restart on an item reloads the estimate and covariance from them, a zero denominator
// gives gain 0 and flags the step.
module scalar_kalman_filter #(
   parameter int FRAC_BITS    = skf_pkg::FRAC_BITS_DEF,
   parameter int SAMPLE_WIDTH = skf_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,

   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [skf_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  logic [((SAMPLE_WIDTH > FRAC_BITS + 2) ? SAMPLE_WIDTH : FRAC_BITS + 2)-1:0]
                                                   csr_data,

   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // measurement
   input  logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] req_tdata,
   // restart
   input  logic                                    req_tuser,
   input  logic                                    req_tlast,

   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // estimate, gain, covariance
   output logic [((SAMPLE_WIDTH + 2 * FRAC_BITS + 3 + 7) / 8) * 8-1:0] rsp_tdata,
   // step_invalid, run_invalid
   output logic [1:0]                              rsp_tuser
);
   import skf_pkg::*;

   localparam int SW       = SAMPLE_WIDTH;
   localparam int NOISE_W  = FRAC_BITS + 1;
   localparam int GAIN_W   = FRAC_BITS + 1;
   localparam int COV_W    = FRAC_BITS + 2;
   localparam int PP_W     = FRAC_BITS + 3;
   localparam int DEN_W    = FRAC_BITS + 4;
   localparam int DIFF_W   = SW + 1;
   localparam int PX_W     = GAIN_W + 1 + DIFF_W;
   localparam int PP_PROD_W = GAIN_W + PP_W;
   localparam int CNT_W    = $clog2(FRAC_BITS + 1);
   localparam int OUT_W    = ((SW + 2 * FRAC_BITS + 3 + 7) / 8) * 8;

   localparam longint ONE_L   = longint'(1) << FRAC_BITS;
   localparam longint TENTH_L = (ONE_L + 5) / 10;
   localparam longint X0_L    = (ONE_L * 39 + 50) / 100;

   localparam logic [NOISE_W-1:0] RST_NOISE = NOISE_W'(TENTH_L);
   localparam logic [COV_W-1:0]   RST_COV   = COV_W'(TENTH_L);
   localparam logic [SW-1:0]      RST_X0    = SW'(X0_L);

   localparam logic [GAIN_W-1:0]         ONE     = GAIN_W'(ONE_L);
   localparam logic [CNT_W-1:0]          CNT_TOP = CNT_W'(FRAC_BITS);
   localparam logic signed [PX_W-1:0]    HALF_X  = PX_W'(ONE_L >> 1);
   localparam logic [PP_PROD_W-1:0]      HALF_P  = PP_PROD_W'(ONE_L >> 1);
   localparam logic signed [PX_W-1:0]    SMAX    = (PX_W'(1) << (SW - 1)) - PX_W'(1);
   localparam logic signed [PX_W-1:0]    SMIN    = -SMAX - PX_W'(1);
   localparam logic [PP_PROD_W-1:0]      COV_MAX = (PP_PROD_W'(1) << COV_W) - PP_PROD_W'(1);

   // configuration registers
   logic [NOISE_W-1:0] q_ff, r_ff;
   logic [SW-1:0]      x0_ff;
   logic [COV_W-1:0]   p0_ff;

   // filter state
   logic [SW-1:0]    x_ff;
   logic [COV_W-1:0] p_ff;
   logic             run_seen_ff;

   // sequencer
   logic [PC_W-1:0] pc_ff, pc_in;
   ucode_type       uc;
   logic            hold;

   // datapath
   logic [SW-1:0]               m_ff;
   logic                        last_ff;
   logic [PP_W-1:0]             pp_ff;
   logic [DEN_W-1:0]            den_ff;
   logic [DEN_W:0]              rem_ff;
   logic [GAIN_W-1:0]           quot_ff;
   logic [CNT_W-1:0]            cnt_ff;
   logic                        bad_ff;
   logic signed [PX_W-1:0]      prodx_ff;
   logic [PP_PROD_W-1:0]        prodp_ff;

   // result register
   logic                 rsp_tvalid_ff;
   logic [SW-1:0]        est_ff;
   logic [GAIN_W-1:0]    gain_ff;
   logic [COV_W-1:0]     cov_ff;
   logic                 step_bad_ff;
   logic                 run_bad_ff;

   logic                        req_accept;
   logic                        out_busy;
   logic [DEN_W-1:0]            den_w;
   logic [DEN_W:0]              trial_w;
   logic                        fits_w;
   logic [GAIN_W-1:0]           k_w;
   logic signed [DIFF_W-1:0]    diff_w;
   logic signed [GAIN_W:0]      k_s;
   logic signed [PX_W-1:0]      xsum_w;
   logic [SW-1:0]               x_new;
   logic [PP_PROD_W-1:0]        pr_w;
   logic [COV_W-1:0]            p_new;
   logic                        run_any;

   assign uc         = ucode_rom(pc_ff);
   assign csr_ready  = 1'b1;
   assign req_tready = (uc.op == OP_WAIT);
   assign req_accept = req_tvalid && req_tready;
   assign out_busy   = rsp_tvalid_ff && !rsp_tready;

   always_comb begin
      case (uc.hold)
         HOLD_NEVER:    hold = 1'b0;
         HOLD_NO_ITEM:  hold = !req_tvalid;
         HOLD_DIV_BUSY: hold = (cnt_ff != '0);
         HOLD_OUT_BUSY: hold = out_busy;
         default:       hold = 1'b0;
      endcase
      pc_in = hold ? pc_ff : uc.target;
   end

   // divider step; the first iteration compares pp itself, later ones the doubled remainder
   assign den_w   = DEN_W'(pp_ff) + DEN_W'(r_ff);
   assign trial_w = (cnt_ff == CNT_TOP) ? rem_ff : {rem_ff[DEN_W-1:0], 1'b0};
   assign fits_w  = (trial_w >= {1'b0, den_ff});

   // zero denominator forces gain 0, which leaves x as is and p at pp
   assign k_w    = bad_ff ? '0 : quot_ff;
   assign diff_w = {m_ff[SW-1], m_ff} - {x_ff[SW-1], x_ff};
   assign k_s    = {1'b0, k_w};

   always_comb begin
      xsum_w = PX_W'($signed(x_ff)) + ((prodx_ff + HALF_X) >>> FRAC_BITS);
      if (xsum_w > SMAX) begin
         x_new = SMAX[SW-1:0];
      end else if (xsum_w < SMIN) begin
         x_new = SMIN[SW-1:0];
      end else begin
         x_new = xsum_w[SW-1:0];
      end
      pr_w = (prodp_ff + HALF_P) >> FRAC_BITS;
      p_new = (pr_w > COV_MAX) ? COV_MAX[COV_W-1:0] : pr_w[COV_W-1:0];
      run_any = run_seen_ff || bad_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff         <= STEP_WAIT;
         q_ff          <= RST_NOISE;
         r_ff          <= RST_NOISE;
         x0_ff         <= RST_X0;
         p0_ff         <= RST_COV;
         x_ff          <= RST_X0;
         p_ff          <= RST_COV;
         run_seen_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         pc_ff <= pc_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_PROCESS_NOISE:      q_ff  <= csr_data[NOISE_W-1:0];
               REG_MEASUREMENT_NOISE:  r_ff  <= csr_data[NOISE_W-1:0];
               REG_INITIAL_ESTIMATE:   x0_ff <= csr_data[SW-1:0];
               REG_INITIAL_COVARIANCE: p0_ff <= csr_data[COV_W-1:0];
               default: ;
            endcase
         end
         if (req_accept && req_tuser) begin
            x_ff <= x0_ff;
            p_ff <= p0_ff;
         end
         if (uc.op == OP_WRITE && !out_busy) begin
            x_ff          <= x_new;
            p_ff          <= p_new;
            run_seen_ff   <= last_ff ? 1'b0 : run_any;
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (uc.op)
         OP_WAIT: begin
            if (req_accept) begin
               m_ff    <= req_tdata[SW-1:0];
               last_ff <= req_tlast;
            end
         end
         OP_ADDPP: begin
            pp_ff <= PP_W'(p_ff) + PP_W'(q_ff);
         end
         OP_SETUP: begin
            den_ff <= den_w;
            rem_ff <= (DEN_W + 1)'(pp_ff);
            bad_ff <= (den_w == '0);
            cnt_ff <= CNT_TOP;
         end
         OP_DIV: begin
            rem_ff  <= fits_w ? trial_w - {1'b0, den_ff} : trial_w;
            quot_ff <= {quot_ff[GAIN_W-2:0], fits_w};
            cnt_ff  <= cnt_ff - CNT_W'(1);
         end
         OP_MULX: begin
            prodx_ff <= diff_w * k_s;
         end
         OP_MULP: begin
            prodp_ff <= (ONE - k_w) * pp_ff;
         end
         OP_WRITE: begin
            if (!out_busy) begin
               est_ff      <= x_new;
               gain_ff     <= k_w;
               cov_ff      <= p_new;
               step_bad_ff <= bad_ff;
               run_bad_ff  <= last_ff && run_any;
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = OUT_W'({cov_ff, gain_ff, est_ff});
   assign rsp_tuser  = {run_bad_ff, step_bad_ff};

`include "scalar_kalman_filter_assert.svh"

   `SKF_ASSERT_NEXT(a_accept_starts_program, clock, reset, req_accept, pc_ff == STEP_ADDPP)
   `SKF_ASSERT_NOW(a_bad_step_zero, clock, reset, rsp_tvalid_ff && step_bad_ff,
                   gain_ff == '0 && cov_ff == '0)
   `SKF_ASSERT_NOW(a_gain_at_most_one, clock, reset, rsp_tvalid_ff, gain_ff <= ONE)
   `SKF_ASSERT_NOW(a_div_remainder_below, clock, reset,
                   uc.op == OP_DIV && cnt_ff != CNT_TOP && !bad_ff, rem_ff < {1'b0, den_ff})

endmodule

>>> sim/tb.sv
// self-checking testbench for scalar_kalman_filter: random and directed samples, checked
// against a fixed-point predictor held in a small scoreboard class
// depends on skf_pkg and the scalar_kalman_filter rtl
`timescale 1ns / 1ps

module tb;

   localparam int FB    = skf_pkg::FRAC_BITS_DEF;
   localparam int SW    = skf_pkg::SAMPLE_WIDTH_DEF;
   localparam int GW    = FB + 1;
   localparam int CW    = FB + 2;
   localparam int CSRW  = (SW > CW) ? SW : CW;
   localparam int TDW   = ((SW + 7) / 8) * 8;
   localparam int RDW   = ((SW + 2 * FB + 3 + 7) / 8) * 8;
   localparam int IXW   = skf_pkg::CSR_INDEX_W;

   localparam longint ONE    = 64'd1 << FB;
   localparam longint CMAX   = (64'd1 << CW) - 1;
   localparam longint SMAX   = (64'd1 << (SW - 1)) - 1;
   localparam longint SMIN   = -SMAX - 1;
   localparam longint NMAX   = ONE;
   localparam longint P0MAX  = 2 * ONE;

   localparam int SETTLE_CYCLES    = 40;
   localparam int HOLD_CYCLES      = 400;
   localparam int WATCHDOG_LIMIT   = 5000;
   localparam int RAND_PHASES      = 12;
   localparam int ITEMS_PER_PHASE  = 111;
   localparam int PRESSURE_PHASE   = 3;
   localparam int ZERO_NOISE_PHASE = 7;

   typedef struct {
      logic [SW-1:0] estimate;
      logic [GW-1:0] gain;
      logic [CW-1:0] covariance;
      logic          step_bad;
      logic          run_bad;
   } kf_out_type;

   class kalman_board;
      longint  q_noise, r_noise, x_init, p_init;
      longint  x_est, p_cov;
      bit      run_bad_seen;
      kf_out_type pending[$];
      int      errors;

      function new();
         q_noise      = (ONE + 5) / 10;
         r_noise      = (ONE + 5) / 10;
         x_init       = (ONE * 39 + 50) / 100;
         p_init       = (ONE + 5) / 10;
         x_est        = x_init;
         p_cov        = p_init;
         run_bad_seen = 1'b0;
         errors       = 0;
      endfunction

      function void set_reg(logic [IXW-1:0] idx, logic [CSRW-1:0] val);
         case (idx)
            skf_pkg::REG_PROCESS_NOISE:      q_noise = val[GW-1:0];
            skf_pkg::REG_MEASUREMENT_NOISE:  r_noise = val[GW-1:0];
            skf_pkg::REG_INITIAL_ESTIMATE:   x_init  = longint'($signed(val[SW-1:0]));
            skf_pkg::REG_INITIAL_COVARIANCE: p_init  = val[CW-1:0];
            default: ;
         endcase
      endfunction

      // divide by ONE, nearest with ties upward
      function longint round_q(longint v);
         return (v + (ONE >> 1)) >>> FB;
      endfunction

      function void note_sample(logic [SW-1:0] m_bits, logic rs, logic lst);
         longint  m, pp, den, k, x, pn;
         bit      bad;
         kf_out_type e;
         m = longint'($signed(m_bits));
         if (rs) begin
            x_est = x_init;
            p_cov = p_init;
         end
         pp  = p_cov + q_noise;
         den = pp + r_noise;
         bad = (den == 0);
         k   = bad ? 0 : (pp << FB) / den;
         if (k > ONE) k = ONE;
         x = x_est + round_q(k * (m - x_est));
         if (x > SMAX) x = SMAX;
         if (x < SMIN) x = SMIN;
         pn = round_q((ONE - k) * pp);
         if (pn > CMAX) pn = CMAX;
         x_est = x;
         p_cov = pn;
         if (bad) run_bad_seen = 1'b1;
         e.run_bad = 1'b0;
         if (lst) begin
            e.run_bad    = run_bad_seen;
            run_bad_seen = 1'b0;
         end
         e.estimate   = x[SW-1:0];
         e.gain       = k[GW-1:0];
         e.covariance = pn[CW-1:0];
         e.step_bad   = bad;
         pending.push_back(e);
      endfunction

      function void compare(string what, longint want, longint got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %h got %h", $time, what, want, got);
            errors++;
         end
      endfunction

      function void check_result(logic [RDW-1:0] d, logic [1:0] u);
         kf_out_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result, expected none got %h / %b", $time, d, u);
            errors++;
            return;
         end
         e = pending.pop_front();
         compare("estimate", e.estimate, d[SW-1:0]);
         compare("gain", e.gain, d[SW+GW-1:SW]);
         compare("covariance", e.covariance, d[SW+GW+CW-1:SW+GW]);
         compare("padding", 0, d[RDW-1:SW+GW+CW]);
         compare("step_invalid", e.step_bad, u[0]);
         compare("run_invalid", e.run_bad, u[1]);
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_valid;
   logic              csr_ready;
   logic [IXW-1:0]    csr_index;
   logic [CSRW-1:0]   csr_data;
   logic              req_tvalid;
   logic              req_tready;
   logic [TDW-1:0]    req_tdata;
   logic              req_tuser;
   logic              req_tlast;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RDW-1:0]    rsp_tdata;
   logic [1:0]        rsp_tuser;

   kalman_board board;
   bit          send_calm = 1'b0;
   bit          take_calm = 1'b0;
   bit          hold_req  = 1'b0;
   int          idle_cycles = 0;

   scalar_kalman_filter uut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   function automatic int pick_gap();
      int roll;
      if (send_calm) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 26);
      return $urandom_range(30, 80);
   endfunction

   function automatic int pick_stall();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 26);
      return $urandom_range(40, 120);
   endfunction

   function automatic longint pick_level(longint lo, longint hi);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 15) return lo;
      if (roll < 30) return hi;
      return lo + longint'($urandom_range(0, int'(hi - lo)));
   endfunction

   function automatic logic [SW-1:0] pick_measurement();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) begin
         case ($urandom_range(0, 3))
            0:       return {1'b1, {(SW-1){1'b0}}};
            1:       return {1'b0, {(SW-1){1'b1}}};
            2:       return '0;
            default: return '1;
         endcase
      end
      if (roll < 5) return SW'($urandom);
      // near the running estimate, where the filter spends most of its life
      return SW'(board.x_est + longint'($urandom_range(0, 1 << 19)) - (1 << 18));
   endfunction

   // restart travels on tuser, last sample on tlast
   task automatic send_sample(input logic [SW-1:0] m, input logic rs, input logic lst);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= TDW'(m);
      req_tuser  <= rs;
      req_tlast  <= lst;
      do @(posedge clock); while (!req_tready);
      board.note_sample(m, rs, lst);
   endtask

   task automatic send_run(ref int left);
      int   len;
      logic rs, lst;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      for (int i = 0; i < len && left > 0; i++) begin
         rs  = (i == 0) ? ($urandom_range(0, 9) < 7) : ($urandom_range(0, 29) == 0);
         lst = (i == len - 1 || left == 1) ? ($urandom_range(0, 9) != 0)
                                           : ($urandom_range(0, 29) == 0);
         send_sample(pick_measurement(), rs, lst);
         left--;
      end
   endtask

   // registers are only touched with the block drained
   task automatic settle();
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(input longint qv, input longint rv, input longint xv,
                               input longint pv);
      logic [IXW-1:0]  idxs [4];
      logic [CSRW-1:0] vals [4];
      idxs = '{skf_pkg::REG_PROCESS_NOISE, skf_pkg::REG_MEASUREMENT_NOISE,
               skf_pkg::REG_INITIAL_ESTIMATE, skf_pkg::REG_INITIAL_COVARIANCE};
      vals = '{CSRW'(qv), CSRW'(rv), CSRW'(xv), CSRW'(pv)};
      csr_valid <= 1'b1;
      for (int i = 0; i < 4; i++) begin
         csr_index <= idxs[i];
         csr_data  <= vals[i];
         do @(posedge clock); while (!csr_ready);
         board.set_reg(idxs[i], vals[i]);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin : take_side
      int stall;
      stall = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            board.check_result(rsp_tdata, rsp_tuser);
         if (hold_req) begin
            stall    = HOLD_CYCLES;
            hold_req = 1'b0;
         end
         if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else if (take_calm || $urandom_range(0, 9) < 7) begin
            rsp_tready <= 1'b1;
         end else begin
            stall = pick_stall() - 1;
            rsp_tready <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : drive_side
      int left;
      board = new();
      reset      <= 1'b1;
      csr_valid  <= 1'b0;
      csr_index  <= skf_pkg::REG_PROCESS_NOISE;
      csr_data   <= '0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      req_tlast  <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset values of all registers, every data bit both ways
      send_sample(24'h000000, 1'b0, 1'b0);
      send_sample(24'h7fffff, 1'b0, 1'b0);
      send_sample(24'h800000, 1'b0, 1'b0);
      send_sample(24'hffffff, 1'b0, 1'b1);
      send_sample(24'h000001, 1'b1, 1'b0);
      send_sample(24'h555555, 1'b0, 1'b0);
      send_sample(24'haaaaaa, 1'b0, 1'b1);

      // all noise and covariance zero: zero denominator on every step
      settle();
      write_config(0, 0, SMIN, 0);
      send_sample(24'h7fffff, 1'b1, 1'b0);
      send_sample(24'h000000, 1'b0, 1'b1);
      send_sample(24'h800000, 1'b0, 1'b0);

      // unit gain collapses p to zero, next step is invalid; restart keeps run flag
      settle();
      write_config(0, 0, SMAX, P0MAX);
      send_sample(24'h800000, 1'b1, 1'b0);
      send_sample(24'h123456, 1'b0, 1'b0);
      send_sample(24'h000000, 1'b1, 1'b1);
      send_sample(24'h7fffff, 1'b1, 1'b1);

      // largest noise and covariance
      settle();
      write_config(NMAX, NMAX, SMAX, P0MAX);
      send_sample(24'h800000, 1'b1, 1'b0);
      send_sample(24'h7fffff, 1'b0, 1'b0);
      send_sample(24'h000000, 1'b0, 1'b1);
      send_sample(24'h800000, 1'b1, 1'b1);

      // no measurement noise: gain is exactly one
      settle();
      write_config(NMAX, 0, 0, 0);
      send_sample(24'h400000, 1'b1, 1'b0);
      send_sample(24'hc00000, 1'b0, 1'b1);

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         settle();
         if (ph == ZERO_NOISE_PHASE)
            write_config(0, 0, pick_level(SMIN, SMAX), $urandom_range(0, 2));
         else
            write_config(pick_level(0, NMAX), pick_level(0, NMAX), pick_level(SMIN, SMAX),
                         pick_level(0, P0MAX));
         send_calm = ($urandom_range(0, 4) == 0);
         take_calm = ($urandom_range(0, 4) == 0);
         if (ph == PRESSURE_PHASE) begin
            // sink holds off while samples keep coming, so the input backs up
            send_calm = 1'b1;
            take_calm = 1'b0;
            hold_req  = 1'b1;
         end
         left = ITEMS_PER_PHASE;
         while (left > 0) send_run(left);
      end

      settle();
      if (board.errors == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
